>>> rtl/bandwidth_admission_table_top_macros.svh
// ----------------------------------------------------------------------------
// Bandwidth admission table assertion macros
// Shared property templates for the admission table checks.
// ----------------------------------------------------------------------------
`ifndef BANDWIDTH_ADMISSION_TABLE_TOP_MACROS_SVH
`define BANDWIDTH_ADMISSION_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define BAT_ASSERT_IMPL(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("bat: same-cycle check failed");

// next-cycle implication
`define BAT_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("bat: next-cycle check failed");

`endif

>>> rtl/bat_pkg.sv
// ----------------------------------------------------------------------------
// Bandwidth admission table package
// Shared types, codes and constants of the admission table.
// ----------------------------------------------------------------------------
package bat_pkg;

    localparam int MAX_STREAMS_DEF = 16;

    localparam logic [31:0] TOTAL_BW_RST   = 32'd1000000000;
    localparam logic [15:0] FIRST_PORT_RST = 16'd6100;

    localparam int ALU_W = 34;

    localparam logic [ALU_W-1:0] AUDIO_BW     = ALU_W'(8000 * 16);
    localparam logic [ALU_W-1:0] LOW_PIX_BW   = ALU_W'(24 * 320 * 240);
    localparam logic [ALU_W-1:0] HIGH_PIX_BW  = ALU_W'(24 * 640 * 480);

    typedef enum logic [1:0] {
        FN_ADMIT  = 2'd0,
        FN_CHANGE = 2'd1,
        FN_SWITCH = 2'd2,
        FN_REMOVE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REJECT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        CFG_TOTAL_BW   = 1'b0,
        CFG_FIRST_PORT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic        wr;
        logic        clr;
        logic [15:0] port;
        logic [31:0] bw;
        logic        mode;
    } tbl_wr_t;

    typedef struct packed {
        logic        vld;
        logic [15:0] port;
        logic [31:0] bw;
        logic        mode;
    } tbl_rd_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] port;
        logic [31:0] bw;
        logic [31:0] remaining;
        logic        mode;
    } res_t;

endpackage

>>> rtl/bat_alu.sv
// ----------------------------------------------------------------------------
// Bandwidth admission table adder
// Shared 34-bit add/subtract unit used by the sequencer's arithmetic steps.
// ----------------------------------------------------------------------------
module bat_alu (
    input  logic [bat_pkg::ALU_W-1:0] a,
    input  logic [bat_pkg::ALU_W-1:0] b,
    input  logic                      sub,
    output logic [bat_pkg::ALU_W-1:0] y
);

    logic [bat_pkg::ALU_W-1:0] b_eff;

    assign b_eff = sub ? ~b : b;
    assign y     = a + b_eff + bat_pkg::ALU_W'(sub);

endmodule

>>> rtl/bat_table.sv
// ----------------------------------------------------------------------------
// Bandwidth admission table storage
// Stream entry memory with registered read and per-entry valid flags.
// ----------------------------------------------------------------------------
module bat_table #(
    parameter int MAX_STREAMS = bat_pkg::MAX_STREAMS_DEF,
    parameter int IDX_W       = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output bat_pkg::tbl_rd_t rd,
    input  logic [IDX_W-1:0] wr_idx,
    input  bat_pkg::tbl_wr_t wr
);

    logic [15:0]            port_mem [MAX_STREAMS];
    logic [31:0]            bw_mem   [MAX_STREAMS];
    logic                   mode_mem [MAX_STREAMS];
    logic [MAX_STREAMS-1:0] valid_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [15:0]            rd_port_reg;
    logic [31:0]            rd_bw_reg;
    logic                   rd_mode_reg;

    always_ff @(posedge clk)
    begin
        if (wr.wr)
        begin
            port_mem[wr_idx] <= wr.port;
            bw_mem[wr_idx]   <= wr.bw;
            mode_mem[wr_idx] <= wr.mode;
        end
        if (rd_en)
        begin
            rd_idx_reg  <= rd_idx;
            rd_port_reg <= port_mem[rd_idx];
            rd_bw_reg   <= bw_mem[rd_idx];
            rd_mode_reg <= mode_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.wr)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
        else if (wr.clr)
        begin
            valid_reg[wr_idx] <= 1'b0;
        end
    end

    assign rd.vld  = valid_reg[rd_idx_reg];
    assign rd.port = rd_port_reg;
    assign rd.bw   = rd_bw_reg;
    assign rd.mode = rd_mode_reg;

endmodule

>>> rtl/bat_ctrl.sv
// ----------------------------------------------------------------------------
// Bandwidth admission table sequencer
// Steps each request through the shared adder and the entry scan.
// ----------------------------------------------------------------------------
module bat_ctrl #(
    parameter int MAX_STREAMS = bat_pkg::MAX_STREAMS_DEF,
    parameter int IDX_W       = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       func,
    input  logic             audio_active,
    input  logic             high_resolution,
    input  logic [7:0]       frame_rate,
    input  logic [15:0]      stream_port,
    input  logic [31:0]      new_bandwidth,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_data,
    output logic             rd_en,
    output logic [IDX_W-1:0] rd_idx,
    input  bat_pkg::tbl_rd_t rd,
    output logic [IDX_W-1:0] wr_idx,
    output bat_pkg::tbl_wr_t wr,
    output logic             res_valid,
    output bat_pkg::res_t    res,
    input  logic             out_free
);

    localparam int CNT_W = $clog2(MAX_STREAMS + 1);
    localparam int AW    = bat_pkg::ALU_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MUL   = 10'b00_0000_0010,
        S_AUD   = 10'b00_0000_0100,
        S_CHK   = 10'b00_0000_1000,
        S_SCAN  = 10'b00_0001_0000,
        S_ADMIT = 10'b00_0010_0000,
        S_RET   = 10'b00_0100_0000,
        S_SUM   = 10'b00_1000_0000,
        S_NET   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    bat_pkg::func_t     func_reg, func_next;
    logic               audio_reg, audio_next;
    logic [15:0]        port_reg, port_next;
    logic [31:0]        nbw_reg, nbw_next;
    logic [AW-1:0]      acc_reg, acc_next;
    logic [AW-1:0]      pix_reg, pix_next;
    logic [7:0]         rate_reg, rate_next;
    logic [2:0]         mul_cnt_reg, mul_cnt_next;
    logic [31:0]        diff_reg, diff_next;
    logic [AW-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic               cmp_pend_reg, cmp_pend_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [31:0]        ebw_reg, ebw_next;
    logic               emode_reg, emode_next;
    logic [31:0]        remaining_reg, remaining_next;
    logic [15:0]        next_port_reg, next_port_next;
    bat_pkg::res_t      res_reg, res_next;

    logic [AW-1:0]      alu_a;
    logic [AW-1:0]      alu_b;
    logic               alu_sub;
    logic [AW-1:0]      alu_y;
    logic               hit;
    logic [31:0]        alu_sat;
    logic               new_mode;

    bat_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y)
    );

    assign alu_sat  = (alu_y[AW-1:32] != '0) ? 32'hFFFF_FFFF : alu_y[31:0];
    assign new_mode = emode_reg ^ (func_reg == bat_pkg::FN_SWITCH);
    assign hit      = (func_reg == bat_pkg::FN_ADMIT) ? !rd.vld
                                                      : (rd.vld && (rd.port == port_reg));

    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_MUL:
            begin
                alu_b = rate_reg[0] ? pix_reg : '0;
            end
            S_AUD:
            begin
                alu_b = audio_reg ? bat_pkg::AUDIO_BW : '0;
            end
            S_CHK:
            begin
                alu_a   = AW'(remaining_reg);
                alu_b   = acc_reg;
                alu_sub = 1'b1;
            end
            S_RET, S_SUM:
            begin
                alu_a = AW'(remaining_reg);
                alu_b = AW'(ebw_reg);
            end
            S_NET:
            begin
                alu_a   = sum_reg;
                alu_b   = AW'(nbw_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = acc_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        audio_next     = audio_reg;
        port_next      = port_reg;
        nbw_next       = nbw_reg;
        acc_next       = acc_reg;
        pix_next       = pix_reg;
        rate_next      = rate_reg;
        mul_cnt_next   = mul_cnt_reg;
        diff_next      = diff_reg;
        sum_next       = sum_reg;
        scan_cnt_next  = scan_cnt_reg;
        cmp_pend_next  = cmp_pend_reg;
        cmp_idx_next   = cmp_idx_reg;
        slot_next      = slot_reg;
        ebw_next       = ebw_reg;
        emode_next     = emode_reg;
        remaining_next = remaining_reg;
        next_port_next = next_port_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        rd_idx         = scan_cnt_reg[IDX_W-1:0];
        wr_idx         = slot_reg;
        wr             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next     = bat_pkg::func_t'(func);
                    audio_next    = audio_active;
                    port_next     = stream_port;
                    nbw_next      = new_bandwidth;
                    acc_next      = '0;
                    pix_next      = high_resolution ? bat_pkg::HIGH_PIX_BW
                                                    : bat_pkg::LOW_PIX_BW;
                    rate_next     = frame_rate;
                    mul_cnt_next  = '0;
                    scan_cnt_next = '0;
                    cmp_pend_next = 1'b0;
                    state_next    = (bat_pkg::func_t'(func) == bat_pkg::FN_ADMIT) ? S_MUL
                                                                                : S_SCAN;
                end
                else if (cfg_valid)
                begin
                    unique case (bat_pkg::cfg_idx_t'(cfg_index))
                        bat_pkg::CFG_TOTAL_BW:   remaining_next = cfg_data;
                        bat_pkg::CFG_FIRST_PORT: next_port_next = cfg_data[15:0];
                        default:                 remaining_next = remaining_reg;
                    endcase
                end
            end
            S_MUL:
            begin
                acc_next     = alu_y;
                pix_next     = {pix_reg[AW-2:0], 1'b0};
                rate_next    = {1'b0, rate_reg[7:1]};
                mul_cnt_next = mul_cnt_reg + 3'd1;
                if (mul_cnt_reg == 3'd7)
                begin
                    state_next = S_AUD;
                end
            end
            S_AUD:
            begin
                acc_next   = alu_y;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (alu_y[AW-1])
                begin
                    res_next   = '{bat_pkg::ST_REJECT, 16'd0, acc_reg[31:0], 32'd0, 1'b0};
                    state_next = S_OUT;
                end
                else
                begin
                    diff_next  = alu_y[31:0];
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg != CNT_W'(MAX_STREAMS))
                begin
                    rd_en         = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[IDX_W-1:0];
                    cmp_pend_next = 1'b1;
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    cmp_pend_next = 1'b0;
                end
                if (cmp_pend_reg)
                begin
                    if (hit)
                    begin
                        slot_next     = cmp_idx_reg;
                        ebw_next      = rd.bw;
                        emode_next    = rd.mode;
                        cmp_pend_next = 1'b0;
                        unique case (func_reg)
                            bat_pkg::FN_ADMIT:  state_next = S_ADMIT;
                            bat_pkg::FN_REMOVE: state_next = S_RET;
                            default:            state_next = S_SUM;
                        endcase
                    end
                    else if (cmp_idx_reg == IDX_W'(MAX_STREAMS - 1))
                    begin
                        cmp_pend_next = 1'b0;
                        state_next    = S_OUT;
                        if (func_reg == bat_pkg::FN_ADMIT)
                        begin
                            res_next = '{bat_pkg::ST_FULL, 16'd0, acc_reg[31:0], 32'd0, 1'b0};
                        end
                        else
                        begin
                            res_next = '{bat_pkg::ST_NOTFOUND, port_reg, 32'd0, 32'd0, 1'b0};
                        end
                    end
                end
            end
            S_ADMIT:
            begin
                wr             = '{1'b1, 1'b0, next_port_reg, acc_reg[31:0], audio_reg};
                remaining_next = diff_reg;
                next_port_next = next_port_reg + 16'd1;
                res_next       = '{bat_pkg::ST_OK, next_port_reg, acc_reg[31:0], 32'd0,
                                   audio_reg};
                state_next     = S_OUT;
            end
            S_RET:
            begin
                wr             = '{1'b0, 1'b1, 16'd0, 32'd0, 1'b0};
                remaining_next = alu_sat;
                res_next       = '{bat_pkg::ST_OK, port_reg, ebw_reg, 32'd0, emode_reg};
                state_next     = S_OUT;
            end
            S_SUM:
            begin
                sum_next   = alu_y;
                state_next = S_NET;
            end
            S_NET:
            begin
                if (!alu_y[AW-1] && (alu_y != '0))
                begin
                    wr             = '{1'b1, 1'b0, port_reg, nbw_reg, new_mode};
                    remaining_next = alu_sat;
                    res_next       = '{bat_pkg::ST_OK, port_reg, nbw_reg, 32'd0, new_mode};
                end
                else
                begin
                    res_next = '{bat_pkg::ST_REJECT, port_reg, ebw_reg, 32'd0, emode_reg};
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mul_cnt_reg   <= '0;
            scan_cnt_reg  <= '0;
            cmp_pend_reg  <= 1'b0;
            remaining_reg <= bat_pkg::TOTAL_BW_RST;
            next_port_reg <= bat_pkg::FIRST_PORT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            mul_cnt_reg   <= mul_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            cmp_pend_reg  <= cmp_pend_next;
            remaining_reg <= remaining_next;
            next_port_reg <= next_port_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        audio_reg   <= audio_next;
        port_reg    <= port_next;
        nbw_reg     <= nbw_next;
        acc_reg     <= acc_next;
        pix_reg     <= pix_next;
        rate_reg    <= rate_next;
        diff_reg    <= diff_next;
        sum_reg     <= sum_next;
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        ebw_reg     <= ebw_next;
        emode_reg   <= emode_next;
        res_reg     <= res_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE) && !in_valid;
    assign res_valid     = (state_reg == S_OUT);
    assign res.status    = res_reg.status;
    assign res.port      = res_reg.port;
    assign res.bw        = res_reg.bw;
    assign res.remaining = remaining_reg;
    assign res.mode      = res_reg.mode;

endmodule

>>> rtl/bandwidth_admission_table_top.sv
// ----------------------------------------------------------------------------
// Bandwidth admission table
// Admission control over a table of streams sharing one bandwidth pool.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one request word (func and its
// operands). in_stall is high while a request is in progress.
// Output channel: out_valid/out_stall carry one result word per request,
// held in an output register so a stalled result does not block the next
// request from starting.
// Config channel: cfg_valid/cfg_ready write total_bandwidth (index 0, also
// reloads the pool) or first_port (index 1, reloads the port counter);
// cfg_ready is high only between requests while no request is offered.
// An admit request runs eight shift-add steps for the frame-rate product,
// the audio add, the bandwidth check, a scan through the single read
// port of the entry memory, then the update.
// Reset empties the table, loads the pool with 1000000000 and the port
// counter with 6100. A stalled result waits; the next request then waits in
// its last step until the output register frees.
// ----------------------------------------------------------------------------
`include "bandwidth_admission_table_top_macros.svh"

module bandwidth_admission_table_top #(
    parameter int MAX_STREAMS = bat_pkg::MAX_STREAMS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic        audio_active,
    input  logic        high_resolution,
    input  logic [7:0]  frame_rate,
    input  logic [15:0] stream_port,
    input  logic [31:0] new_bandwidth,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] granted_port,
    output logic [31:0] stream_bandwidth,
    output logic [31:0] remaining_bandwidth,
    output logic        mode_active,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;

    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    bat_pkg::tbl_rd_t rd;
    logic [IDX_W-1:0] wr_idx;
    bat_pkg::tbl_wr_t wr;
    logic             res_valid;
    bat_pkg::res_t    res;
    logic             out_free;
    logic             out_valid_reg;
    bat_pkg::res_t    out_reg;

    bat_ctrl #(
        .MAX_STREAMS (MAX_STREAMS),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .audio_active    (audio_active),
        .high_resolution (high_resolution),
        .frame_rate      (frame_rate),
        .stream_port     (stream_port),
        .new_bandwidth   (new_bandwidth),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rd_en           (rd_en),
        .rd_idx          (rd_idx),
        .rd              (rd),
        .wr_idx          (wr_idx),
        .wr              (wr),
        .res_valid       (res_valid),
        .res             (res),
        .out_free        (out_free)
    );

    bat_table #(
        .MAX_STREAMS (MAX_STREAMS),
        .IDX_W       (IDX_W)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (rd_en),
        .rd_idx (rd_idx),
        .rd     (rd),
        .wr_idx (wr_idx),
        .wr     (wr)
    );

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid           = out_valid_reg;
    assign status              = out_reg.status;
    assign granted_port        = out_reg.port;
    assign stream_bandwidth    = out_reg.bw;
    assign remaining_bandwidth = out_reg.remaining;
    assign mode_active         = out_reg.mode;

    `BAT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `BAT_ASSERT_IMPL(a_notfound_fields, out_valid && (status == bat_pkg::ST_NOTFOUND),
                     (stream_bandwidth == 32'd0) && !mode_active)
    `BAT_ASSERT_IMPL(a_full_fields, out_valid && (status == bat_pkg::ST_FULL),
                     (granted_port == 16'd0) && !mode_active)
    `BAT_ASSERT_IMPL(a_cfg_only_idle, cfg_ready, !in_stall)

endmodule

>>> test/bandwidth_admission_table_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bandwidth admission table testbench
// Sends admit, change, switch and remove requests through the valid/stall
// channel, keeps its own copy of the stream table and bandwidth pool to
// predict every result word, and checks the results in order. Covers exact
// fits, a full table, port wrap with duplicate ports, pool saturation, a long
// output hold-off and several budget and port settings with random traffic.
// ----------------------------------------------------------------------------
module bandwidth_admission_table_top_test;

    localparam int          SLOTS        = bat_pkg::MAX_STREAMS_DEF;
    localparam int          SETTLE       = 40;
    localparam int          MAX_REPORTS  = 10;
    localparam longint      POOL_MAX     = 64'd4294967295;
    localparam logic [31:0] AUDIO_RATE   = 32'd128000;
    localparam logic [31:0] LOW_RES_BW   = 32'd1843200;
    localparam logic [31:0] HIGH_RES_BW  = 32'd7372800;

    typedef struct packed {
        bat_pkg::func_t func;
        logic           audio;
        logic           hires;
        logic [7:0]     rate;
        logic [15:0]    port;
        logic [31:0]    bw;
    } request_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic        audio_active;
    logic        high_resolution;
    logic [7:0]  frame_rate;
    logic [15:0] stream_port;
    logic [31:0] new_bandwidth;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [15:0] granted_port;
    logic [31:0] stream_bandwidth;
    logic [31:0] remaining_bandwidth;
    logic        mode_active;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    logic          slot_used [SLOTS];
    logic [15:0]   slot_port [SLOTS];
    logic [31:0]   slot_bw   [SLOTS];
    logic          slot_mode [SLOTS];
    logic [31:0]   pool;
    logic [15:0]   port_counter;
    bat_pkg::res_t pending_results [$];

    int mismatches = 0;
    int unexpected = 0;
    int reports    = 0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_req   = 1'b0;
    int hold_len   = 0;

    bandwidth_admission_table_top dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .func                (func),
        .audio_active        (audio_active),
        .high_resolution     (high_resolution),
        .frame_rate          (frame_rate),
        .stream_port         (stream_port),
        .new_bandwidth       (new_bandwidth),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .status              (status),
        .granted_port        (granted_port),
        .stream_bandwidth    (stream_bandwidth),
        .remaining_bandwidth (remaining_bandwidth),
        .mode_active         (mode_active),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void reset_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            slot_port[i] = '0;
            slot_bw[i]   = '0;
            slot_mode[i] = 1'b0;
        end
        pool         = bat_pkg::TOTAL_BW_RST;
        port_counter = bat_pkg::FIRST_PORT_RST;
    endfunction

    function automatic int find_stream(logic [15:0] p);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_port[i] == p)
                return i;
        return -1;
    endfunction

    function automatic int first_used();
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i])
                return i;
        return -1;
    endfunction

    function automatic int pick_stream();
        int live [$];
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i])
                live.push_back(i);
        if (live.size() == 0)
            return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function automatic bat_pkg::res_t admission_outcome(request_t rq);
        bat_pkg::res_t r;
        logic [31:0]   need;
        longint        after;
        int            s;
        r = '0;
        if (rq.func == bat_pkg::FN_ADMIT)
        begin
            need = (rq.audio ? AUDIO_RATE : 32'd0)
                 + (rq.hires ? HIGH_RES_BW : LOW_RES_BW) * {24'd0, rq.rate};
            r.bw = need;
            if (pool < need)
                r.status = bat_pkg::ST_REJECT;
            else
            begin
                s = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!slot_used[i])
                        s = i;
                if (s < 0)
                    r.status = bat_pkg::ST_FULL;
                else
                begin
                    slot_used[s] = 1'b1;
                    slot_port[s] = port_counter;
                    slot_bw[s]   = need;
                    slot_mode[s] = rq.audio;
                    pool         = pool - need;
                    r.status     = bat_pkg::ST_OK;
                    r.port       = port_counter;
                    r.mode       = rq.audio;
                    port_counter = port_counter + 16'd1;
                end
            end
        end
        else
        begin
            s      = find_stream(rq.port);
            r.port = rq.port;
            if (s < 0)
                r.status = bat_pkg::ST_NOTFOUND;
            else if (rq.func == bat_pkg::FN_REMOVE)
            begin
                after        = {32'd0, pool} + {32'd0, slot_bw[s]};
                pool         = (after > POOL_MAX) ? 32'hFFFF_FFFF : after[31:0];
                slot_used[s] = 1'b0;
                r.status     = bat_pkg::ST_OK;
                r.bw         = slot_bw[s];
                r.mode       = slot_mode[s];
            end
            else
            begin
                after = {32'd0, pool} + {32'd0, slot_bw[s]} - {32'd0, rq.bw};
                if (after > 0)
                begin
                    pool       = (after > POOL_MAX) ? 32'hFFFF_FFFF : after[31:0];
                    slot_bw[s] = rq.bw;
                    if (rq.func == bat_pkg::FN_SWITCH)
                        slot_mode[s] = ~slot_mode[s];
                    r.status = bat_pkg::ST_OK;
                end
                else
                    r.status = bat_pkg::ST_REJECT;
                r.bw   = slot_bw[s];
                r.mode = slot_mode[s];
            end
        end
        r.remaining = pool;
        return r;
    endfunction

    function automatic request_t admit_req(logic audio, logic hires, logic [7:0] rate);
        request_t rq;
        rq       = '0;
        rq.func  = bat_pkg::FN_ADMIT;
        rq.audio = audio;
        rq.hires = hires;
        rq.rate  = rate;
        return rq;
    endfunction

    function automatic request_t stream_req(bat_pkg::func_t f, logic [15:0] p,
                                            logic [31:0] bw);
        request_t rq;
        rq      = '0;
        rq.func = f;
        rq.port = p;
        rq.bw   = bw;
        return rq;
    endfunction

    // mostly well-formed: ports of live streams and bandwidths around the room left
    function automatic request_t random_request();
        request_t    rq;
        logic [32:0] room;
        int          s;
        int          sel;
        rq.func  = bat_pkg::FN_ADMIT;
        rq.audio = 1'($urandom);
        rq.hires = 1'($urandom);
        rq.rate  = 8'($urandom);
        rq.port  = 16'($urandom);
        rq.bw    = $urandom;
        sel      = $urandom_range(0, 99);
        s        = pick_stream();
        if (sel < 35)
        begin
            if ($urandom_range(0, 2) != 0)
                rq.rate = 8'($urandom_range(0, 15));
        end
        else if (sel < 90 && s >= 0)
        begin
            rq.port = slot_port[s];
            rq.func = (sel < 55) ? bat_pkg::FN_CHANGE
                    : (sel < 70) ? bat_pkg::FN_SWITCH : bat_pkg::FN_REMOVE;
            room    = {1'b0, pool} + {1'b0, slot_bw[s]};
            case ($urandom_range(0, 5))
                0: rq.bw = room[32] ? 32'hFFFF_FFFF : room[31:0];
                1: rq.bw = room[32] ? 32'($urandom) : room[31:0] - 32'd1;
                2: rq.bw = $urandom_range(0, 40_000_000);
                3: rq.bw = slot_bw[s];
                4: rq.bw = '0;
                default: rq.bw = $urandom;
            endcase
        end
        else if (sel >= 90)
            rq.func = bat_pkg::func_t'(2'($urandom_range(0, 3)));
        return rq;
    endfunction

    task automatic send_request(request_t rq);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        func            <= rq.func;
        audio_active    <= rq.audio;
        high_resolution <= rq.hires;
        frame_rate      <= rq.rate;
        stream_port     <= rq.port;
        new_bandwidth   <= rq.bw;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(admission_outcome(rq));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(bat_pkg::cfg_idx_t idx, logic [31:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == bat_pkg::CFG_TOTAL_BW)
            pool = value;
        else
            port_counter = value[15:0];
    endtask

    task automatic empty_table();
        int s;
        s = first_used();
        while (s >= 0)
        begin
            send_request(stream_req(bat_pkg::FN_REMOVE, slot_port[s], '0));
            s = first_used();
        end
    endtask

    task automatic test_basic_requests();
        send_request(admit_req(1'b0, 1'b0, 8'd0));
        send_request(admit_req(1'b1, 1'b1, 8'd255));
        send_request(admit_req(1'b1, 1'b1, 8'd30));
        send_request(admit_req(1'b0, 1'b0, 8'd25));
        send_request(stream_req(bat_pkg::FN_CHANGE, bat_pkg::FIRST_PORT_RST + 16'd1,
                                32'd5000000));
        send_request(stream_req(bat_pkg::FN_CHANGE, bat_pkg::FIRST_PORT_RST + 16'd1,
                                32'hFFFF_FFFF));
        send_request(stream_req(bat_pkg::FN_SWITCH, bat_pkg::FIRST_PORT_RST + 16'd2,
                                32'd1000));
        send_request(stream_req(bat_pkg::FN_SWITCH, bat_pkg::FIRST_PORT_RST + 16'd2,
                                32'hFFFF_FFFF));
        send_request(stream_req(bat_pkg::FN_REMOVE, bat_pkg::FIRST_PORT_RST, '0));
        send_request(stream_req(bat_pkg::FN_REMOVE, bat_pkg::FIRST_PORT_RST, '0));
        send_request(stream_req(bat_pkg::FN_CHANGE, 16'd0, 32'd1));
        send_request(stream_req(bat_pkg::FN_SWITCH, 16'hFFFF, 32'd0));
        send_request(stream_req(bat_pkg::FN_REMOVE, bat_pkg::FIRST_PORT_RST + 16'd2, '0));
        empty_table();
    endtask

    task automatic test_exact_fit();
        write_register(bat_pkg::CFG_TOTAL_BW, AUDIO_RATE + LOW_RES_BW * 32'd10);
        send_request(admit_req(1'b1, 1'b0, 8'd10));
        send_request(admit_req(1'b0, 1'b1, 8'd0));
        send_request(admit_req(1'b0, 1'b0, 8'd1));
        send_request(stream_req(bat_pkg::FN_CHANGE, slot_port[0], slot_bw[0]));
        send_request(stream_req(bat_pkg::FN_CHANGE, slot_port[0], slot_bw[0] - 32'd1));
        send_request(stream_req(bat_pkg::FN_SWITCH, slot_port[1], 32'd2));
        send_request(stream_req(bat_pkg::FN_SWITCH, slot_port[1], 32'd0));
        empty_table();
    endtask

    task automatic test_full_table();
        write_register(bat_pkg::CFG_TOTAL_BW, 32'hFFFF_FFFF);
        write_register(bat_pkg::CFG_FIRST_PORT, 32'd0);
        for (int i = 0; i < SLOTS; i++)
            send_request(admit_req(i[0], i[1], i[7:0]));
        send_request(admit_req(1'b1, 1'b1, 8'd255));
        send_request(admit_req(1'b0, 1'b0, 8'd0));
        send_request(stream_req(bat_pkg::FN_REMOVE, slot_port[5], '0));
        send_request(admit_req(1'b1, 1'b0, 8'd7));
        empty_table();
    endtask

    task automatic test_wrap_and_saturation();
        write_register(bat_pkg::CFG_TOTAL_BW, bat_pkg::TOTAL_BW_RST);
        write_register(bat_pkg::CFG_FIRST_PORT, 32'h0000_FFFF);
        send_request(admit_req(1'b0, 1'b0, 8'd2));
        send_request(admit_req(1'b1, 1'b0, 8'd3));
        write_register(bat_pkg::CFG_FIRST_PORT, 32'h0000_FFFF);
        send_request(admit_req(1'b0, 1'b1, 8'd1));
        write_register(bat_pkg::CFG_TOTAL_BW, 32'hFFFF_FFFF);
        send_request(stream_req(bat_pkg::FN_CHANGE, 16'hFFFF, 32'd10));
        send_request(stream_req(bat_pkg::FN_REMOVE, 16'hFFFF, '0));
        send_request(stream_req(bat_pkg::FN_REMOVE, 16'hFFFF, '0));
        send_request(stream_req(bat_pkg::FN_REMOVE, 16'd0, '0));
        write_register(bat_pkg::CFG_TOTAL_BW, 32'd0);
        send_request(admit_req(1'b0, 1'b0, 8'd0));
        send_request(admit_req(1'b0, 1'b0, 8'd1));
        send_request(stream_req(bat_pkg::FN_CHANGE, slot_port[0], 32'd0));
        empty_table();
    endtask

    task automatic test_output_hold();
        drain_results();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_len   = 400;
        hold_req   = 1'b1;
        repeat (12) send_request(random_request());
        drain_results();
    endtask

    task automatic test_random_traffic(logic [31:0] budget, logic [15:0] base_port,
                                       int count, bit idle);
        write_register(bat_pkg::CFG_TOTAL_BW, budget);
        write_register(bat_pkg::CFG_FIRST_PORT, {16'd0, base_port});
        tx_idle_en = idle;
        rx_idle_en = idle;
        repeat (count) send_request(random_request());
        drain_results();
    endtask

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_result
        bat_pkg::res_t seen;
        bat_pkg::res_t want;
        if (rst_n === 1'b1 && out_valid && !out_stall)
        begin
            seen.status    = bat_pkg::status_t'(status);
            seen.port      = granted_port;
            seen.bw        = stream_bandwidth;
            seen.remaining = remaining_bandwidth;
            seen.mode      = mode_active;
            if (pending_results.size() == 0)
            begin
                unexpected++;
                reports++;
                if (reports <= MAX_REPORTS)
                    $display("unexpected result word: status %0d port %0d bw %0d",
                             status, granted_port, stream_bandwidth);
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen.status !== want.status || seen.port !== want.port
                    || seen.bw !== want.bw || seen.remaining !== want.remaining
                    || seen.mode !== want.mode)
                begin
                    mismatches++;
                    reports++;
                    if (reports <= MAX_REPORTS)
                        $display("mismatch (exp/act): status %0d/%0d port %0d/%0d",
                                 want.status, seen.status, want.port, seen.port,
                                 " bw %0d/%0d rem %0d/%0d mode %0d/%0d",
                                 want.bw, seen.bw, want.remaining, seen.remaining,
                                 want.mode, seen.mode);
                end
            end
        end
    end

    initial
    begin
        #15_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        func            <= bat_pkg::FN_ADMIT;
        audio_active    <= 1'b0;
        high_resolution <= 1'b0;
        frame_rate      <= '0;
        stream_port     <= '0;
        new_bandwidth   <= '0;
        cfg_valid       <= 1'b0;
        cfg_index       <= bat_pkg::CFG_TOTAL_BW;
        cfg_data        <= '0;
        reset_table();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_requests();
        test_exact_fit();
        test_full_table();
        test_wrap_and_saturation();
        test_output_hold();
        test_random_traffic(32'hFFFF_FFFF, 16'd0, 360, 1'b1);
        test_random_traffic(32'd0, 16'hFFFF, 360, 1'b1);
        test_random_traffic(bat_pkg::TOTAL_BW_RST, bat_pkg::FIRST_PORT_RST, 360, 1'b1);
        test_random_traffic($urandom, 16'($urandom), 360, 1'b1);
        test_random_traffic(bat_pkg::TOTAL_BW_RST, 16'hFFF8, 360, 1'b0);

        if (mismatches + unexpected + pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
